### sv/ttsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch tap and swipe classifier package
// Shared constants, configuration layout, command, direction and state codes.
// ----------------------------------------------------------------------------
package ttsc_pkg;

    // Fixed field widths of the configuration registers and the ports.
    localparam int CFG_RAW_W   = 12;
    localparam int CFG_SIZE_W  = 11;
    localparam int CFG_TAP_W   = 11;
    localparam int CFG_SLIDE_W = 10;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int CMD_W       = 2;
    localparam int DIR_W       = 3;

    // Depth of the job queue between the front and the back end.
    localparam int QUEUE_DEPTH = 2;

    // Reset values of the configuration registers.
    localparam logic [CFG_RAW_W-1:0]   RST_RAW_MIN  = 12'd0;
    localparam logic [CFG_RAW_W-1:0]   RST_RAW_MAX  = 12'd4095;
    localparam logic [CFG_SIZE_W-1:0]  RST_WIDTH    = 11'd800;
    localparam logic [CFG_SIZE_W-1:0]  RST_HEIGHT   = 11'd480;
    localparam logic [CFG_TAP_W-1:0]   RST_TAP_LIM  = 11'd20;
    localparam logic [CFG_SLIDE_W-1:0] RST_SLIDE    = 10'd30;

    typedef enum logic [CMD_W-1:0] {
        CMD_RAW_X   = 2'd0,
        CMD_RAW_Y   = 2'd1,
        CMD_PRESS   = 2'd2,
        CMD_RELEASE = 2'd3
    } t_cmd;

    // Swipe directions in screen coordinates: positive X is to the right,
    // positive Y is downward.
    typedef enum logic [DIR_W-1:0] {
        DIR_TAP   = 3'd0,
        DIR_POS_X = 3'd1,
        DIR_NEG_X = 3'd2,
        DIR_POS_Y = 3'd3,
        DIR_NEG_Y = 3'd4
    } t_dir;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_MIN  = 3'd0,
        CFG_X_MAX  = 3'd1,
        CFG_Y_MIN  = 3'd2,
        CFG_Y_MAX  = 3'd3,
        CFG_WIDTH  = 3'd4,
        CFG_HEIGHT = 3'd5,
        CFG_TAP    = 3'd6,
        CFG_SLIDE  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_RAW_W-1:0]   x_min;
        logic [CFG_RAW_W-1:0]   x_max;
        logic [CFG_RAW_W-1:0]   y_min;
        logic [CFG_RAW_W-1:0]   y_max;
        logic [CFG_SIZE_W-1:0]  width;
        logic [CFG_SIZE_W-1:0]  height;
        logic [CFG_TAP_W-1:0]   tap;
        logic [CFG_SLIDE_W-1:0] slide;
    } t_cfg;

    // Queue status seen by the producer and the consumer.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [2:0] {
        BK_IDLE = 3'd0,
        BK_MUL  = 3'd1,
        BK_CMP  = 3'd2,
        BK_DIV  = 3'd3,
        BK_DONE = 3'd4
    } t_back_state;

endpackage

### sv/ttsc_evt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch event channel
// Valid and ready handshake carrying one touch command and its raw sample.
// ----------------------------------------------------------------------------
interface ttsc_evt_if #(
    parameter int ADC_BITS = 12
);
    logic                valid;
    logic                ready;
    logic [1:0]          command;
    logic [ADC_BITS-1:0] sample;

    modport source (output valid, output command, output sample, input ready);
    modport sink   (input valid, input command, input sample, output ready);
endinterface

### sv/ttsc_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gesture result channel
// Valid and ready handshake carrying one classified press and release pair.
// ----------------------------------------------------------------------------
interface ttsc_res_if #(
    parameter int PIXEL_BITS = 10
);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] press_x;
    logic [PIXEL_BITS-1:0] press_y;
    logic [PIXEL_BITS-1:0] mid_x;
    logic [PIXEL_BITS-1:0] mid_y;
    logic [2:0]            direction;
    logic                  is_tap;

    modport source (
        output valid, output press_x, output press_y, output mid_x, output mid_y,
        output direction, output is_tap, input ready
    );
    modport sink (
        input valid, input press_x, input press_y, input mid_x, input mid_y,
        input direction, input is_tap, output ready
    );
endinterface

### sv/ttsc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch event front end
// Holds the raw coordinates and turns press and release events into jobs.
// ----------------------------------------------------------------------------
module ttsc_front #(
    parameter int ADC_BITS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ttsc_evt_if.sink             i_evt,
    input  ttsc_pkg::t_q_stat    i_q_stat,
    output logic                 o_push,
    output logic [2*ADC_BITS:0]  o_job
);
    import ttsc_pkg::*;

    logic [ADC_BITS-1:0] r_held_x, n_held_x;
    logic [ADC_BITS-1:0] r_held_y, n_held_y;
    logic                accept;
    logic                is_touch;
    t_cmd                cmd;

    // Events are taken whenever the job queue has room.
    assign i_evt.ready = !i_q_stat.full;
    assign accept      = i_evt.valid && i_evt.ready;
    assign cmd         = t_cmd'(i_evt.command);

    // Raw samples update the held coordinates; touches become jobs.
    always_comb begin
        n_held_x = r_held_x;
        n_held_y = r_held_y;
        is_touch = 1'b0;
        unique case (cmd)
            CMD_RAW_X:   n_held_x = i_evt.sample;
            CMD_RAW_Y:   n_held_y = i_evt.sample;
            CMD_PRESS,
            CMD_RELEASE: is_touch = 1'b1;
        endcase
    end

    // A job snapshots the held coordinates at the time of the transfer.
    assign o_push = accept && is_touch;
    assign o_job  = {cmd == CMD_RELEASE, r_held_y, r_held_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_x <= '0;
            r_held_y <= '0;
        end else if (accept) begin
            r_held_x <= n_held_x;
            r_held_y <= n_held_y;
        end
    end

endmodule

### sv/ttsc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job queue
// Small register FIFO that decouples the event front end from the mapper.
// ----------------------------------------------------------------------------
module ttsc_queue #(
    parameter int WIDTH = 25
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [WIDTH-1:0]  i_data,
    input  logic              i_pop,
    output logic [WIDTH-1:0]  o_data,
    output ttsc_pkg::t_q_stat o_stat
);
    import ttsc_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW  = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNTW-1:0]  r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    assign o_stat.full  = (r_count == CNTW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_data       = r_mem[r_rd_ptr];

    // Pointer and fill count update with wrap at the queue depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(r_wr_ptr + 1'b1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(r_rd_ptr + 1'b1);
        end
        priority if (do_push && !do_pop) begin
            n_count = CNTW'(r_count + 1'b1);
        end else if (do_pop && !do_push) begin
            n_count = CNTW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset; the fill count guards every read.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### sv/ttsc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel mapper and gesture back end
// Maps both axes through a shared multiply and serial divider, then records
// the press point or classifies the release into a registered result.
// ----------------------------------------------------------------------------
module ttsc_back #(
    parameter int ADC_BITS   = 12,
    parameter int PIXEL_BITS = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ttsc_pkg::t_cfg      i_cfg,
    input  ttsc_pkg::t_q_stat   i_q_stat,
    input  logic [2*ADC_BITS:0] i_job,
    output logic                o_pop,
    ttsc_res_if.source          o_res
);
    import ttsc_pkg::*;

    localparam int RW        = (ADC_BITS > CFG_RAW_W) ? ADC_BITS : CFG_RAW_W;
    localparam int NW        = RW + CFG_SIZE_W;
    localparam int SW        = CFG_SIZE_W + 2;
    localparam int PIX_RANGE = 1 << PIXEL_BITS;
    localparam int CNTW      = $clog2(PIXEL_BITS);
    localparam int CW        = (PIXEL_BITS + 1 > CFG_TAP_W) ? PIXEL_BITS + 1 : CFG_TAP_W;

    t_back_state             r_state, n_state;
    logic                    r_axis, n_axis;
    logic [NW-1:0]           r_num, n_num;
    logic [NW-1:0]           r_lim, n_lim;
    logic [CFG_RAW_W-1:0]    r_span, n_span;
    logic [CFG_SIZE_W-1:0]   r_size, n_size;
    logic                    r_zero, n_zero;
    logic [CFG_RAW_W-1:0]    r_rem, n_rem;
    logic [PIXEL_BITS-1:0]   r_quo, n_quo;
    logic [CNTW-1:0]         r_cnt, n_cnt;
    logic [PIXEL_BITS-1:0]   r_px_x, n_px_x;
    logic [PIXEL_BITS-1:0]   r_px_y, n_px_y;
    logic [PIXEL_BITS-1:0]   r_press_x, n_press_x;
    logic [PIXEL_BITS-1:0]   r_press_y, n_press_y;

    logic                    r_res_valid, n_res_valid;
    logic [PIXEL_BITS-1:0]   r_res_press_x, r_res_press_y;
    logic [PIXEL_BITS-1:0]   r_res_mid_x, r_res_mid_y;
    t_dir                    r_res_dir;
    logic                    r_res_tap;

    // Job fields.
    logic                    job_rel;
    logic [ADC_BITS-1:0]     job_raw_x, job_raw_y;

    // Axis operands.
    logic [ADC_BITS-1:0]     sel_raw;
    logic [CFG_RAW_W-1:0]    sel_lo, sel_hi;
    logic [CFG_SIZE_W-1:0]   sel_size, size_sat;
    logic [RW-1:0]           raw_ext, lo_ext;
    logic [NW-1:0]           mul_num, mul_lim;
    logic                    mul_zero;

    // Divider step.
    logic [CFG_RAW_W:0]      div_t, div_r;
    logic                    div_ge;
    logic [PIXEL_BITS-1:0]   div_q;
    logic                    div_last;

    // Pixel write-back.
    logic                    px_wr;
    logic [PIXEL_BITS-1:0]   px_val;

    // Classification.
    logic                    x_pos, y_pos;
    logic [PIXEL_BITS-1:0]   adx, ady;
    logic [CW-1:0]           manhattan;
    logic                    swipe;
    t_dir                    dir;
    logic [PIXEL_BITS:0]     sum_x, sum_y;
    logic                    out_free;
    logic                    res_load;

    assign job_rel   = i_job[2*ADC_BITS];
    assign job_raw_y = i_job[2*ADC_BITS-1:ADC_BITS];
    assign job_raw_x = i_job[ADC_BITS-1:0];

    // Operand selection for the axis in work; the size saturates at the pixel range.
    assign sel_raw  = r_axis ? job_raw_y : job_raw_x;
    assign sel_lo   = r_axis ? i_cfg.y_min : i_cfg.x_min;
    assign sel_hi   = r_axis ? i_cfg.y_max : i_cfg.x_max;
    assign sel_size = r_axis ? i_cfg.height : i_cfg.width;
    assign size_sat = ({2'b00, sel_size} > SW'(PIX_RANGE)) ? CFG_SIZE_W'(PIX_RANGE) : sel_size;
    assign raw_ext  = RW'(sel_raw);
    assign lo_ext   = RW'(sel_lo);

    // Scaled offset and the limit at which the quotient reaches the size.
    assign mul_num  = NW'(raw_ext - lo_ext) * NW'(size_sat);
    assign mul_lim  = NW'(sel_hi - sel_lo) * NW'(size_sat);
    assign mul_zero = (sel_hi <= sel_lo) || (size_sat == '0) || (raw_ext <= lo_ext);

    // One restoring division step a cycle, most significant quotient bit first.
    assign div_t    = {r_rem, r_quo[PIXEL_BITS-1]};
    assign div_ge   = (div_t >= {1'b0, r_span});
    assign div_r    = div_ge ? (div_t - {1'b0, r_span}) : div_t;
    assign div_q    = {r_quo[PIXEL_BITS-2:0], div_ge};
    assign div_last = (r_cnt == CNTW'(PIXEL_BITS - 1));

    // Release classification from the press point and the freshly mapped point.
    assign x_pos     = (r_px_x > r_press_x);
    assign y_pos     = (r_px_y > r_press_y);
    assign adx       = x_pos ? (r_px_x - r_press_x) : (r_press_x - r_px_x);
    assign ady       = y_pos ? (r_px_y - r_press_y) : (r_press_y - r_px_y);
    assign manhattan = CW'(adx) + CW'(ady);
    assign swipe     = (CW'(adx) >= CW'(i_cfg.slide)) || (CW'(ady) >= CW'(i_cfg.slide));
    assign sum_x     = {1'b0, r_press_x} + {1'b0, r_px_x};
    assign sum_y     = {1'b0, r_press_y} + {1'b0, r_px_y};

    // Ties between the axes go horizontal.
    always_comb begin
        priority if (!swipe) begin
            dir = DIR_TAP;
        end else if (adx >= ady) begin
            dir = x_pos ? DIR_POS_X : DIR_NEG_X;
        end else begin
            dir = y_pos ? DIR_POS_Y : DIR_NEG_Y;
        end
    end

    assign out_free = !r_res_valid || o_res.ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_state = BK_MUL;
                end
            end
            BK_MUL: n_state = BK_CMP;
            BK_CMP: begin
                if (r_zero || (r_num >= r_lim)) begin
                    n_state = r_axis ? BK_DONE : BK_MUL;
                end else begin
                    n_state = BK_DIV;
                end
            end
            BK_DIV: begin
                if (div_last) begin
                    n_state = r_axis ? BK_DONE : BK_MUL;
                end
            end
            BK_DONE: begin
                if (!job_rel || out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // Datapath control and next values.
    always_comb begin
        n_axis    = r_axis;
        n_num     = r_num;
        n_lim     = r_lim;
        n_span    = r_span;
        n_size    = r_size;
        n_zero    = r_zero;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_cnt     = r_cnt;
        n_px_x    = r_px_x;
        n_px_y    = r_px_y;
        n_press_x = r_press_x;
        n_press_y = r_press_y;
        px_wr     = 1'b0;
        px_val    = '0;
        o_pop     = 1'b0;
        res_load  = 1'b0;
        unique case (r_state)
            BK_IDLE: n_axis = 1'b0;
            BK_MUL: begin
                n_num  = mul_num;
                n_lim  = mul_lim;
                n_span = sel_hi - sel_lo;
                n_size = size_sat;
                n_zero = mul_zero;
            end
            BK_CMP: begin
                priority if (r_zero) begin
                    px_wr  = 1'b1;
                    px_val = '0;
                end else if (r_num >= r_lim) begin
                    px_wr  = 1'b1;
                    px_val = PIXEL_BITS'(r_size - 1'b1);
                end else begin
                    n_rem = CFG_RAW_W'(r_num >> PIXEL_BITS);
                    n_quo = r_num[PIXEL_BITS-1:0];
                    n_cnt = '0;
                end
            end
            BK_DIV: begin
                n_rem = div_r[CFG_RAW_W-1:0];
                n_quo = div_q;
                n_cnt = CNTW'(r_cnt + 1'b1);
                if (div_last) begin
                    px_wr  = 1'b1;
                    px_val = div_q;
                end
            end
            BK_DONE: begin
                priority if (!job_rel) begin
                    n_press_x = r_px_x;
                    n_press_y = r_px_y;
                    o_pop     = 1'b1;
                end else if (out_free) begin
                    res_load = 1'b1;
                    o_pop    = 1'b1;
                end
            end
            default: n_axis = 1'b0;
        endcase
        // The X pixel is written first, then the Y axis starts.
        if (px_wr) begin
            if (!r_axis) begin
                n_px_x = px_val;
                n_axis = 1'b1;
            end else begin
                n_px_y = px_val;
            end
        end
    end

    // The result register holds until its transfer completes.
    always_comb begin
        priority if (res_load) begin
            n_res_valid = 1'b1;
        end else if (o_res.ready) begin
            n_res_valid = 1'b0;
        end else begin
            n_res_valid = r_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_axis      <= 1'b0;
            r_press_x   <= '0;
            r_press_y   <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_press_x   <= n_press_x;
            r_press_y   <= n_press_y;
            r_res_valid <= n_res_valid;
        end
    end

    // Working registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_num  <= n_num;
        r_lim  <= n_lim;
        r_span <= n_span;
        r_size <= n_size;
        r_zero <= n_zero;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_cnt  <= n_cnt;
        r_px_x <= n_px_x;
        r_px_y <= n_px_y;
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_res_press_x <= r_press_x;
            r_res_press_y <= r_press_y;
            r_res_mid_x   <= sum_x[PIXEL_BITS:1];
            r_res_mid_y   <= sum_y[PIXEL_BITS:1];
            r_res_dir     <= dir;
            r_res_tap     <= (manhattan <= CW'(i_cfg.tap));
        end
    end

    assign o_res.valid     = r_res_valid;
    assign o_res.press_x   = r_res_press_x;
    assign o_res.press_y   = r_res_press_y;
    assign o_res.mid_x     = r_res_mid_x;
    assign o_res.mid_y     = r_res_mid_y;
    assign o_res.direction = r_res_dir;
    assign o_res.is_tap    = r_res_tap;

endmodule

### sv/touch_tap_swipe_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch tap and swipe classifier
// Each job is mapped per axis through multiply, compare and divide states (no
// divide when an axis maps to zero or clamps); a release loads the result
// register. Both axes share the serial divider; one job is mapped at a time
// as the queue takes more; raw samples pass one per cycle unless it is full.
// Reset is synchronous: config returns to defaults, held and press points to
// zero, and the job queue and result register empty.
// ----------------------------------------------------------------------------
module touch_tap_swipe_classifier_unit #(
    parameter int ADC_BITS   = 12,
    parameter int PIXEL_BITS = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ttsc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ttsc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    ttsc_evt_if.sink                          i_evt,
    ttsc_res_if.source                        o_res
);
    import ttsc_pkg::*;

    localparam int JOB_W = 2 * ADC_BITS + 1;

    t_cfg              r_cfg, n_cfg;
    t_q_stat           q_stat;
    logic              push;
    logic              pop;
    logic [JOB_W-1:0]  push_job;
    logic [JOB_W-1:0]  head_job;

    // Configuration register write decode.
    always_comb begin
        n_cfg = r_cfg;
        unique case (t_cfg_idx'(i_cfg_idx))
            CFG_X_MIN:  n_cfg.x_min  = i_cfg_data;
            CFG_X_MAX:  n_cfg.x_max  = i_cfg_data;
            CFG_Y_MIN:  n_cfg.y_min  = i_cfg_data;
            CFG_Y_MAX:  n_cfg.y_max  = i_cfg_data;
            CFG_WIDTH:  n_cfg.width  = i_cfg_data[CFG_SIZE_W-1:0];
            CFG_HEIGHT: n_cfg.height = i_cfg_data[CFG_SIZE_W-1:0];
            CFG_TAP:    n_cfg.tap    = i_cfg_data[CFG_TAP_W-1:0];
            CFG_SLIDE:  n_cfg.slide  = i_cfg_data[CFG_SLIDE_W-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_min  <= RST_RAW_MIN;
            r_cfg.x_max  <= RST_RAW_MAX;
            r_cfg.y_min  <= RST_RAW_MIN;
            r_cfg.y_max  <= RST_RAW_MAX;
            r_cfg.width  <= RST_WIDTH;
            r_cfg.height <= RST_HEIGHT;
            r_cfg.tap    <= RST_TAP_LIM;
            r_cfg.slide  <= RST_SLIDE;
        end else if (i_cfg_we) begin
            r_cfg <= n_cfg;
        end
    end

    // Event front end.
    ttsc_front #(
        .ADC_BITS (ADC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_evt    (i_evt),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_job    (push_job)
    );

    // Job queue between front and back.
    ttsc_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .i_pop   (pop),
        .o_data  (head_job),
        .o_stat  (q_stat)
    );

    // Mapper and classifier.
    ttsc_back #(
        .ADC_BITS   (ADC_BITS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_q_stat (q_stat),
        .i_job    (head_job),
        .o_pop    (pop),
        .o_res    (o_res)
    );

endmodule

### sv/ttsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch tap and swipe classifier checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ttsc_checker #(
    parameter int PIXEL_BITS = 10
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_res_valid,
    input logic                  i_res_ready,
    input logic [PIXEL_BITS-1:0] i_press_x,
    input logic [PIXEL_BITS-1:0] i_press_y,
    input logic [PIXEL_BITS-1:0] i_mid_x,
    input logic [PIXEL_BITS-1:0] i_mid_y,
    input logic [2:0]            i_direction,
    input logic                  i_is_tap
);
    import ttsc_pkg::*;

    // A stalled result stays offered.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped before its transfer");

    // A stalled result keeps its payload.
    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
        $stable({i_press_x, i_press_y, i_mid_x, i_mid_y, i_direction, i_is_tap}))
        else $error("result payload changed while stalled");

    // Reset empties the result register.
    a_res_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    // Only defined direction codes leave the block.
    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_direction <= DIR_NEG_Y))
        else $error("undefined direction code");

endmodule

bind touch_tap_swipe_classifier_unit ttsc_checker #(
    .PIXEL_BITS (PIXEL_BITS)
) u_ttsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_press_x   (o_res.press_x),
    .i_press_y   (o_res.press_y),
    .i_mid_x     (o_res.mid_x),
    .i_mid_y     (o_res.mid_y),
    .i_direction (o_res.direction),
    .i_is_tap    (o_res.is_tap)
);
